### src/csr_sparse_matrix_vector_multiply_assert.svh
// assertion macros used by the sparse matrix-vector multiply-accumulate block
// each expects clk and rst_n in the scope of use
`ifndef CSR_SPARSE_MATRIX_VECTOR_MULTIPLY_ASSERT_SVH
`define CSR_SPARSE_MATRIX_VECTOR_MULTIPLY_ASSERT_SVH

// condition holds in the same cycle as the trigger
`define CSMV_ASSERT_SAME(lbl, trig, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cond)) \
    else $error("csmv same-cycle check failed");

// condition holds in the cycle after the trigger
`define CSMV_ASSERT_NEXT(lbl, trig, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
    else $error("csmv next-cycle check failed");

`endif

### src/csmv_pkg.sv
package csmv_pkg;

  // default vector store size
  localparam int CSMV_MAX_DIM = 1024;

  // field widths
  localparam int CSMV_IDX_W   = 10;
  localparam int CSMV_VAL_W   = 32;
  localparam int CSMV_SUM_W   = 64;
  localparam int CSMV_ROWS_W  = 11;
  localparam int CSMV_OP_W    = 2;
  localparam int CSMV_IN_TDATA_W  = 48;
  localparam int CSMV_OUT_TDATA_W = 80;

  // reset value of the row count register
  localparam logic [CSMV_ROWS_W-1:0] CSMV_ROWS_RST = 11'd1024;

  // input item kinds
  typedef enum logic [CSMV_OP_W-1:0] {
    OP_LOAD    = 2'd0,
    OP_NONZERO = 2'd1,
    OP_EMPTY   = 2'd2
  } csmv_op_t;

  // control that travels with an item down the pipeline
  typedef struct packed {
    logic acc;       // item adds a product
    logic close;     // item ends the row
    logic in_range;  // column lies inside the vector store
  } csmv_ctrl_t;

endpackage

### src/csmv_ram.sv
module csmv_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata_r
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

endmodule

### src/csmv_mac.sv
module csmv_mac
  import csmv_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  // configuration
  input  logic                    cfg_we,
  input  logic [CSMV_ROWS_W-1:0]  cfg_wdata,
  // from the vector read stage
  input  logic                    s1_valid,
  input  csmv_ctrl_t              s1_ctrl,
  input  logic [CSMV_VAL_W-1:0]   s1_value,
  input  logic [CSMV_VAL_W-1:0]   vec_rdata,
  output logic                    advance,
  // result
  output logic                    out_valid_r,
  input  logic                    out_ready,
  output logic [CSMV_IDX_W-1:0]   out_row_r,
  output logic [CSMV_SUM_W-1:0]   out_sum_r,
  output logic                    out_sat_r,
  output logic                    out_last_r
);

  localparam logic [CSMV_SUM_W-1:0] SUM_MAX = {1'b0, {(CSMV_SUM_W-1){1'b1}}};
  localparam logic [CSMV_SUM_W-1:0] SUM_MIN = {1'b1, {(CSMV_SUM_W-1){1'b0}}};

  logic                    v2_r;
  csmv_ctrl_t              ctrl2_r;
  logic [CSMV_SUM_W-1:0]   prod_r;
  logic [CSMV_VAL_W-1:0]   operand;
  logic [CSMV_SUM_W-1:0]   acc_r;
  logic [CSMV_SUM_W-1:0]   acc_nxt;
  logic                    sat_r;
  logic                    sat_nxt;
  logic [CSMV_IDX_W-1:0]   cnt_r;
  logic [CSMV_IDX_W-1:0]   cnt_nxt;
  logic [CSMV_ROWS_W-1:0]  rows_r;
  logic [CSMV_ROWS_W-1:0]  last_sel;
  logic                    is_last;
  logic [CSMV_SUM_W:0]     sum_wide;
  logic                    ovf;
  logic [CSMV_SUM_W-1:0]   sum_clip;
  logic                    step;
  logic                    emit;

  // pipeline moves unless a result is held back by the receiver
  assign advance = !out_valid_r || out_ready;
  assign step    = advance && v2_r;
  assign emit    = step && ctrl2_r.close;

  // row count register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_r <= CSMV_ROWS_RST;
    end else if (cfg_we) begin
      rows_r <= cfg_wdata;
    end
  end

  // multiply stage, unused or out-of-range columns read as zero
  assign operand = (s1_ctrl.acc && s1_ctrl.in_range) ? vec_rdata : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (advance) begin
      v2_r <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      ctrl2_r <= s1_ctrl;
      prod_r  <= CSMV_SUM_W'($signed(s1_value) * $signed(operand));
    end
  end

  // saturating accumulate
  always_comb begin
    sum_wide = {acc_r[CSMV_SUM_W-1], acc_r} + {prod_r[CSMV_SUM_W-1], prod_r};
    ovf      = sum_wide[CSMV_SUM_W] != sum_wide[CSMV_SUM_W-1];
    sum_clip = ovf ? (sum_wide[CSMV_SUM_W] ? SUM_MIN : SUM_MAX)
                   : sum_wide[CSMV_SUM_W-1:0];
  end

  // row bookkeeping
  always_comb begin
    last_sel = rows_r - CSMV_ROWS_W'(1);
    is_last  = {1'b0, cnt_r} == last_sel;
    acc_nxt  = acc_r;
    sat_nxt  = sat_r;
    cnt_nxt  = cnt_r;
    if (step) begin
      if (ctrl2_r.close) begin
        acc_nxt = '0;
        sat_nxt = 1'b0;
        cnt_nxt = is_last ? '0 : cnt_r + CSMV_IDX_W'(1);
      end else begin
        acc_nxt = sum_clip;
        sat_nxt = sat_r | ovf;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
      sat_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      acc_r <= acc_nxt;
      sat_r <= sat_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_row_r  <= cnt_r;
      out_sum_r  <= sum_clip;
      out_sat_r  <= sat_r | ovf;
      out_last_r <= is_last;
    end
  end

  `include "csr_sparse_matrix_vector_multiply_assert.svh"

  `CSMV_ASSERT_SAME(a_stall_only_on_result, !advance, out_valid_r)
  `CSMV_ASSERT_NEXT(a_clip_pins_acc, step && !ctrl2_r.close && ovf,
                    acc_r == SUM_MAX || acc_r == SUM_MIN)
  `CSMV_ASSERT_NEXT(a_close_clears_row, emit, acc_r == '0 && !sat_r)
  `CSMV_ASSERT_SAME(a_last_row_wraps, out_valid_r && out_last_r, cnt_r == '0)

endmodule

### src/csr_sparse_matrix_vector_multiply.sv
// Sparse matrix (CSR order) times dense vector, one item per beat.
// Input channel in_*: in_tuser is the item kind (load vector element,
// matrix nonzero, empty row), in_tdata holds the index and the Q16.16 value,
// in_tlast marks the last nonzero of a row. Load the vector first, then
// stream the nonzeros of each row in order; an empty-row beat closes the
// row and yields its sum so far (zero for a true empty row).
// Output channel out_*: one beat per closed row with row index, Q32.32 saturated
// sum, saturation flag in out_tuser and out_tlast on the row equal to num_rows - 1.
// cfg_we/cfg_wdata set num_rows; write only while idle, the block does not enforce it.
// Throughput is one beat per cycle in either direction while out_tready is high; the
// vector store is a single memory read once and written once per cycle at most.
// From the accepting edge to out_tvalid: vector read at the accepting edge,
// multiply register, accumulate into the output register.
// Reset clears the accumulator, row counter and flags and sets num_rows to
// 1024; the vector store is not cleared and must be loaded before use.
// While a result waits with out_tready low, the pipeline holds and in_tready
// drops; nothing is lost or repeated.
module csr_sparse_matrix_vector_multiply
  import csmv_pkg::*;
#(
  parameter int MAX_DIM = CSMV_MAX_DIM
) (
  input  logic                        clk,
  input  logic                        rst_n,
  // configuration
  input  logic                        cfg_we,
  input  logic [CSMV_ROWS_W-1:0]      cfg_wdata,
  // input channel
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [CSMV_IN_TDATA_W-1:0]  in_tdata,   // index[9:0], value[41:10], zero
  input  logic [CSMV_OP_W-1:0]        in_tuser,   // operation[1:0]
  input  logic                        in_tlast,   // last_in_row
  // output channel
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [CSMV_OUT_TDATA_W-1:0] out_tdata,  // row_index[9:0], row_sum[73:10], zero
  output logic                        out_tuser,  // saturated
  output logic                        out_tlast   // last_row
);

  localparam int VEC_DEPTH = (MAX_DIM < (1 << CSMV_IDX_W)) ? MAX_DIM : (1 << CSMV_IDX_W);
  localparam int ADDR_W    = $clog2(VEC_DEPTH);

  logic                    accept;
  logic                    advance;
  csmv_op_t                op;
  logic [CSMV_IDX_W-1:0]   idx;
  logic [CSMV_VAL_W-1:0]   value;
  logic                    in_range;
  logic                    ram_we;
  logic [CSMV_VAL_W-1:0]   ram_rdata;
  logic                    v1_nxt;
  csmv_ctrl_t              ctrl1_nxt;
  logic                    v1_r;
  csmv_ctrl_t              ctrl1_r;
  logic [CSMV_VAL_W-1:0]   val1_r;
  logic [CSMV_IDX_W-1:0]   out_row;
  logic [CSMV_SUM_W-1:0]   out_sum;

  assign in_tready = advance;
  assign accept    = in_tvalid && in_tready;
  assign op        = csmv_op_t'(in_tuser);
  assign idx       = in_tdata[CSMV_IDX_W-1:0];
  assign value     = in_tdata[CSMV_IDX_W +: CSMV_VAL_W];
  assign in_range  = {22'd0, idx} < 32'(MAX_DIM);

  // decode the accepted beat
  always_comb begin
    ram_we    = 1'b0;
    v1_nxt    = 1'b0;
    ctrl1_nxt = '0;
    ctrl1_nxt.in_range = in_range;
    unique case (op)
      OP_LOAD: begin
        ram_we = accept && in_range;
      end
      OP_NONZERO: begin
        v1_nxt          = accept;
        ctrl1_nxt.acc   = 1'b1;
        ctrl1_nxt.close = in_tlast;
      end
      OP_EMPTY: begin
        v1_nxt          = accept;
        ctrl1_nxt.close = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // vector store
  csmv_ram #(
    .WIDTH (CSMV_VAL_W),
    .DEPTH (VEC_DEPTH)
  ) u_vec_ram (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (idx[ADDR_W-1:0]),
    .wdata   (value),
    .re      (accept),
    .raddr   (idx[ADDR_W-1:0]),
    .rdata_r (ram_rdata)
  );

  // read stage registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (advance) begin
      v1_r <= v1_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      ctrl1_r <= ctrl1_nxt;
      val1_r  <= value;
    end
  end

  // multiply, accumulate and result register
  csmv_mac u_mac (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .s1_valid    (v1_r),
    .s1_ctrl     (ctrl1_r),
    .s1_value    (val1_r),
    .vec_rdata   (ram_rdata),
    .advance     (advance),
    .out_valid_r (out_tvalid),
    .out_ready   (out_tready),
    .out_row_r   (out_row),
    .out_sum_r   (out_sum),
    .out_sat_r   (out_tuser),
    .out_last_r  (out_tlast)
  );

  assign out_tdata = {6'd0, out_sum, out_row};

endmodule

### test/testbench.sv
module testbench;
  import csmv_pkg::*;

  localparam int CYCLE_LIMIT = 150000;
  localparam int LONG_HOLD_CYCLES = 64;
  localparam int DRAIN_CYCLES = 8;
  // operation code that the block ignores
  localparam logic [CSMV_OP_W-1:0] OP_RESERVED = 2'd3;

  logic                        clk;
  logic                        rst_n;
  logic                        cfg_we;
  logic [CSMV_ROWS_W-1:0]      cfg_wdata;
  logic                        in_tvalid;
  logic                        in_tready;
  logic [CSMV_IN_TDATA_W-1:0]  in_tdata;   // index[9:0], value[41:10], zero
  logic [CSMV_OP_W-1:0]        in_tuser;   // operation[1:0]
  logic                        in_tlast;   // last_in_row
  logic                        out_tvalid;
  logic                        out_tready;
  logic [CSMV_OUT_TDATA_W-1:0] out_tdata;  // row_index[9:0], row_sum[73:10], zero
  logic                        out_tuser;  // saturated
  logic                        out_tlast;  // last_row

  // one finished row as the block should report it
  typedef struct {
    logic [CSMV_IDX_W-1:0] row;
    logic [CSMV_SUM_W-1:0] sum;
    logic                  sat;
    logic                  last;
  } row_result_t;

  // tracks vector store, row accumulator and row count; holds expected row sums
  class spmv_scoreboard;
    logic [CSMV_VAL_W-1:0]  vec_mem [CSMV_MAX_DIM];
    longint                 acc;
    logic [CSMV_IDX_W-1:0]  row_no;
    logic                   row_sat;
    logic [CSMV_ROWS_W-1:0] rows_cfg;
    row_result_t            expected_rows [$];
    int                     mismatches;

    function void reset_state();
      acc = 0;
      row_no = '0;
      row_sat = 1'b0;
      rows_cfg = CSMV_ROWS_RST;
      expected_rows.delete();
      mismatches = 0;
    endfunction

    function void set_rows(logic [CSMV_ROWS_W-1:0] n);
      rows_cfg = n;
    endfunction

    function int pending();
      return expected_rows.size();
    endfunction

    // saturating add into the row accumulator
    function void add_product(longint p);
      logic signed [CSMV_SUM_W:0] wide;
      wide = {acc[63], acc} + {p[63], p};
      if (wide[CSMV_SUM_W] != wide[CSMV_SUM_W-1]) begin
        acc = wide[CSMV_SUM_W] ? 64'sh8000_0000_0000_0000 : 64'sh7FFF_FFFF_FFFF_FFFF;
        row_sat = 1'b1;
      end else begin
        acc = wide[CSMV_SUM_W-1:0];
      end
    endfunction

    function void close_row();
      row_result_t r;
      r.row = row_no;
      r.sum = acc;
      r.sat = row_sat;
      r.last = ({1'b0, row_no} == rows_cfg - 11'd1);
      expected_rows.push_back(r);
      acc = 0;
      row_sat = 1'b0;
      row_no = r.last ? '0 : row_no + CSMV_IDX_W'(1);
    endfunction

    // called for every accepted input beat
    function void note_item(logic [CSMV_OP_W-1:0] op, logic [CSMV_IDX_W-1:0] col,
                            logic [CSMV_VAL_W-1:0] val, logic last);
      if (op == OP_LOAD) begin
        vec_mem[col] = val;
      end else if (op == OP_NONZERO) begin
        add_product(longint'($signed(val)) * longint'($signed(vec_mem[col])));
        if (last) close_row();
      end else if (op == OP_EMPTY) begin
        close_row();
      end
    endfunction

    // called for every accepted output beat
    function void check_row(logic [CSMV_IDX_W-1:0] row, logic [CSMV_SUM_W-1:0] sum,
                            logic sat, logic last);
      row_result_t want;
      if (expected_rows.size() == 0) begin
        $error("unexpected row result: row_index %0d row_sum %h", row, sum);
        mismatches++;
        return;
      end
      want = expected_rows.pop_front();
      if (row !== want.row) begin
        $error("row_index expected %0d actual %0d", want.row, row);
        mismatches++;
      end
      if (sum !== want.sum) begin
        $error("row_sum expected %h actual %h", want.sum, sum);
        mismatches++;
      end
      if (sat !== want.sat) begin
        $error("saturated expected %0b actual %0b", want.sat, sat);
        mismatches++;
      end
      if (last !== want.last) begin
        $error("last_row expected %0b actual %0b", want.last, last);
        mismatches++;
      end
    endfunction
  endclass

  spmv_scoreboard sums;
  bit             idling;
  bit             rx_hold_req;
  bit             col_loaded [CSMV_MAX_DIM];
  int             loaded_cols [$];
  int             cycle_count;

  csr_sparse_matrix_vector_multiply DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // input beats update the prediction
  always @(posedge clk) begin
    if (rst_n === 1'b1 && in_tvalid && in_tready)
      sums.note_item(in_tuser, in_tdata[9:0], in_tdata[41:10], in_tlast);
  end

  // output beats are checked against the oldest expectation
  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_tvalid && out_tready)
      sums.check_row(out_tdata[9:0], out_tdata[73:10], out_tuser, out_tlast);
  end

  // receiver: short random stalls, plus one long hold on request
  initial begin
    forever begin
      if (rx_hold_req) begin
        rx_hold_req = 1'b0;
        out_tready <= 1'b0;
        repeat (LONG_HOLD_CYCLES) @(posedge clk);
      end else if (idling && $urandom_range(0, 3) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 3)) @(posedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
    end
  end

  // one input beat, with an optional idle burst ahead of it
  task automatic send_beat(input logic [CSMV_OP_W-1:0] op, input logic [CSMV_IDX_W-1:0] col,
                           input logic [CSMV_VAL_W-1:0] val, input logic last);
    if (idling && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {6'd0, val, col};
    in_tlast  <= last;
    if (op == OP_LOAD && !col_loaded[col]) begin
      col_loaded[col] = 1'b1;
      loaded_cols.push_back(int'(col));
    end
    do @(posedge clk); while (!in_tready);
  endtask

  // stop sending and wait for every expected row
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (sums.pending() != 0);
  endtask

  task automatic write_rows(input logic [CSMV_ROWS_W-1:0] n);
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= n;
    @(posedge clk);
    sums.set_rows(n);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [CSMV_VAL_W-1:0] rand_value();
    case ($urandom_range(0, 9))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2, 3, 4: return 32'($signed($urandom_range(0, 32'h7_FFFF)) - 32'sh4_0000);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [CSMV_IDX_W-1:0] pick_col();
    return CSMV_IDX_W'(loaded_cols[$urandom_range(0, loaded_cols.size() - 1)]);
  endfunction

  function automatic logic [CSMV_IDX_W-1:0] rand_col();
    return CSMV_IDX_W'($urandom_range(0, 1023));
  endfunction

  function automatic logic rand_bit();
    return 1'($urandom_range(0, 1));
  endfunction

  // mostly well-formed rows over loaded columns, with loads and noise mixed in
  task automatic random_rows(input int n_items);
    int sent;
    int pick;
    int nnz;
    bit close_empty;
    sent = 0;
    while (sent < n_items) begin
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
        send_beat(OP_LOAD, rand_col(), rand_value(), rand_bit());
        sent++;
      end else if (pick < 12) begin
        send_beat(OP_RESERVED, rand_col(), $urandom, rand_bit());
        sent++;
      end else if (pick < 15) begin
        // stray nonzero left open, merges into the next row
        send_beat(OP_NONZERO, pick_col(), rand_value(), 1'b0);
        sent++;
      end else begin
        nnz = $urandom_range(0, 4);
        close_empty = ($urandom_range(0, 9) == 0);
        for (int j = 0; j < nnz; j++)
          send_beat(OP_NONZERO, pick_col(), rand_value(), (j == nnz - 1) && !close_empty);
        if (nnz == 0 || close_empty)
          send_beat(OP_EMPTY, rand_col(), $urandom, rand_bit());
        sent += nnz + ((nnz == 0 || close_empty) ? 1 : 0);
      end
    end
  endtask

  // main sequence
  initial begin
    sums = new();
    sums.reset_state();
    idling      = 1'b0;
    rx_hold_req = 1'b0;
    rst_n     <= 1'b0;
    cfg_we    <= 1'b0;
    cfg_wdata <= '0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tuser  <= OP_LOAD;
    in_tlast  <= 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: extremes, saturation both ways, empty rows, ignored op
    send_beat(OP_LOAD, 10'd0,    32'h7FFF_FFFF, 1'b1);
    send_beat(OP_LOAD, 10'd1023, 32'h8000_0000, 1'b0);
    send_beat(OP_LOAD, 10'd1,    32'h0001_0000, 1'b0);
    send_beat(OP_LOAD, 10'd2,    32'hFFFF_FFFF, 1'b0);
    send_beat(OP_LOAD, 10'd3,    32'h0000_0000, 1'b0);
    // positive saturation, then continue from the clamped value
    send_beat(OP_NONZERO, 10'd1023, 32'h8000_0000, 1'b0);
    send_beat(OP_NONZERO, 10'd1023, 32'h8000_0000, 1'b0);
    send_beat(OP_NONZERO, 10'd2,    32'h0000_0005, 1'b1);
    // negative saturation
    send_beat(OP_NONZERO, 10'd1023, 32'h7FFF_FFFF, 1'b0);
    send_beat(OP_NONZERO, 10'd1023, 32'h7FFF_FFFF, 1'b0);
    send_beat(OP_NONZERO, 10'd1023, 32'h7FFF_FFFF, 1'b1);
    // true empty row, then an empty-row beat closing an open row
    send_beat(OP_EMPTY, 10'd0, 32'h0, 1'b0);
    send_beat(OP_NONZERO, 10'd1, 32'h0002_0000, 1'b0);
    send_beat(OP_EMPTY, 10'd1023, 32'hFFFF_FFFF, 1'b1);
    // ignored operation
    send_beat(OP_RESERVED, 10'd1023, 32'hFFFF_FFFF, 1'b1);
    // vector load in the middle of a row
    send_beat(OP_NONZERO, 10'd0, 32'h7FFF_FFFF, 1'b0);
    send_beat(OP_LOAD,    10'd4, 32'h1234_5678, 1'b1);
    send_beat(OP_NONZERO, 10'd4, 32'hFFFF_0000, 1'b1);
    send_beat(OP_NONZERO, 10'd3, 32'h7FFF_FFFF, 1'b1);
    send_beat(OP_NONZERO, 10'd0, 32'h8000_0000, 1'b1);
    send_beat(OP_NONZERO, 10'd2, 32'h0000_0000, 1'b1);

    // fill a spread of vector elements
    for (int k = 0; k < 48; k++)
      send_beat(OP_LOAD, rand_col(), rand_value(), rand_bit());

    idling = 1'b1;
    write_rows(11'd1);
    random_rows(200);
    write_rows(11'd2047);
    random_rows(200);
    write_rows(11'd0);
    random_rows(150);

    // long receiver hold while closed rows keep arriving
    write_rows(11'd2);
    idling = 1'b0;
    rx_hold_req = 1'b1;
    for (int k = 0; k < 40; k++)
      send_beat(OP_NONZERO, pick_col(), rand_value(), 1'b1);
    idling = 1'b1;
    random_rows(200);

    write_rows(11'd1025);
    random_rows(150);
    write_rows(CSMV_ROWS_W'($urandom_range(3, 60)));
    random_rows(250);
    write_rows(CSMV_ROWS_RST);
    random_rows(200);

    // closing stretch without idling
    idling = 1'b0;
    write_rows(11'd5);
    random_rows(200);

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sums.mismatches == 0 && sums.pending() == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule
